FILE: rtl/syn_probe_header_builder_core_assert.svh
// Assertion macros used by the SYN probe header builder RTL.
`ifndef SYN_PROBE_HEADER_BUILDER_CORE_ASSERT_SVH
`define SYN_PROBE_HEADER_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPHB_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define SPHB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/sphb_pkg.sv
// Package with header constants and config codes for the SYN probe header builder.
`default_nettype none
package sphb_pkg;

  localparam int unsigned HDR_WORDS = 10;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned PORT_W    = 16;
  localparam int unsigned ADDR_W    = 32;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [IDX_W-1:0] WORD_LAST = IDX_W'(HDR_WORDS - 1);

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IDENT_BASE     = 2'd3;

  // Protocol constants
  localparam logic [15:0] TCP_WINDOW   = 16'd64240;
  localparam logic [15:0] IP_FLAG_DF   = 16'h4000;
  localparam logic [7:0]  IP_TTL       = 8'd64;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [15:0] TCP_FLAG_SYN = 16'h0002;
  localparam logic [15:0] TCP_LEN      = 16'd20;
  localparam logic [15:0] TCP_OFF_FLAGS = 16'h5000 | TCP_FLAG_SYN;

  localparam logic [WORD_W-1:0] WORD_VER_LEN = 32'h4500_0028;
  localparam logic [WORD_W-1:0] WORD_TTL_PROTO = {IP_TTL, PROTO_TCP, 16'h0000};
  localparam logic [WORD_W-1:0] WORD_FLAGS_WIN = {TCP_OFF_FLAGS, TCP_WINDOW};

  // Fixed part of the TCP checksum sum: protocol, length, flags and window
  localparam logic [19:0] CSUM_CONST = 20'(PROTO_TCP) + 20'(TCP_LEN)
                                     + 20'(TCP_OFF_FLAGS) + 20'(TCP_WINDOW);

endpackage
`default_nettype wire

FILE: rtl/syn_probe_header_builder_core.sv
// Top level of the SYN probe header builder: one port in, ten header words out.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------
//  s_ in    | s_tvalid / s_tready     | s_tdata: dest_port
//  m_ out   | m_tvalid / m_tready     | m_tdata: word_index, header_word;
//           |                         | m_tlast: last_word
//  cfg      | cfg_we                  | cfg_index, cfg_data
//
// Each port yields ten words, one per cycle when m_tready stays high, so the
// block works on one port at a time, its ten words sharing the one output
// channel. The next port is accepted in the cycle word 9 is loaded.
// Reset (rst, synchronous) clears the config registers and the valid flags.
// A stall on m_tready holds the output word and stops the word counter.
`default_nettype none
module syn_probe_header_builder_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // config write port
  input  wire logic                                 cfg_we,
  input  wire logic [sphb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sphb_pkg::ADDR_W-1:0]          cfg_data,
  // input words
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [sphb_pkg::PORT_W-1:0]          s_tdata,  // [15:0] dest_port
  // output words
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [sphb_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [3:0] word_index,
                                                              // [35:4] header_word,
                                                              // [39:36] zero
  output logic                                      m_tlast   // last_word
);
  import sphb_pkg::*;

  // Config registers
  logic [ADDR_W-1:0] source_address;
  logic [ADDR_W-1:0] target_address;
  logic [15:0]       source_port;
  logic [15:0]       ident_base;

  // Held probe
  logic              item_valid;
  logic [IDX_W-1:0]  idx;
  logic [15:0]       dport;
  logic [15:0]       ident;
  logic [15:0]       csum;

  // Output word register
  logic              out_valid;
  logic [IDX_W-1:0]  out_index;
  logic [WORD_W-1:0] out_word;
  logic              out_last;

  logic              load_out;
  logic              s_accept;
  logic [WORD_W-1:0] word_sel;
  logic [19:0]       sum_raw;
  logic [16:0]       sum_fold1;
  logic [15:0]       sum_fold2;
  logic [15:0]       ident_next;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      source_address <= '0;
      target_address <= '0;
      source_port    <= '0;
      ident_base     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SOURCE_ADDRESS: source_address <= cfg_data;
        REG_TARGET_ADDRESS: target_address <= cfg_data;
        REG_SOURCE_PORT:    source_port    <= cfg_data[15:0];
        REG_IDENT_BASE:     ident_base     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Handshake control
  assign load_out = item_valid && (!out_valid || m_tready);
  assign s_tready = !item_valid || (load_out && (idx == WORD_LAST));
  assign s_accept = s_tvalid && s_tready;

  // Checksum over pseudo-header and TCP header, folded twice
  always_comb begin
    sum_raw = CSUM_CONST
            + 20'(source_address[31:16]) + 20'(source_address[15:0])
            + 20'(target_address[31:16]) + 20'(target_address[15:0])
            + 20'(source_port) + 20'(s_tdata);
    sum_fold1 = 17'(sum_raw[19:16]) + 17'(sum_raw[15:0]);
    sum_fold2 = 16'(sum_fold1[16]) + sum_fold1[15:0];
    ident_next = ident_base + s_tdata;
  end

  // Probe register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      idx        <= '0;
    end else if (s_accept) begin
      item_valid <= 1'b1;
      idx        <= '0;
    end else if (load_out) begin
      idx <= idx + 1'b1;
      if (idx == WORD_LAST) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      dport <= s_tdata;
      ident <= ident_next;
      csum  <= ~sum_fold2;
    end
  end

  // Header word select
  always_comb begin
    case (idx)
      4'd0:    word_sel = WORD_VER_LEN;
      4'd1:    word_sel = {ident, IP_FLAG_DF};
      4'd2:    word_sel = WORD_TTL_PROTO;
      4'd3:    word_sel = source_address;
      4'd4:    word_sel = target_address;
      4'd5:    word_sel = {source_port, dport};
      4'd8:    word_sel = WORD_FLAGS_WIN;
      4'd9:    word_sel = {csum, 16'h0000};
      default: word_sel = '0;
    endcase
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index <= idx;
      out_word  <= word_sel;
      out_last  <= (idx == WORD_LAST);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'h0, out_word, out_index};
  assign m_tlast  = out_last;

  // Checks
  `include "syn_probe_header_builder_core_assert.svh"

  `SPHB_ASSERT_NOW(a_last_is_word9, clk, rst, m_tvalid && m_tlast, m_tdata[3:0] == WORD_LAST)
  `SPHB_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, item_valid && idx == '0)
  `SPHB_ASSERT_NOW(a_word0_const, clk, rst, m_tvalid && out_index == '0, out_word == WORD_VER_LEN)

endmodule
`default_nettype wire
